// ----- design/swa_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, codes, types and the operation schedule of the skinning weight accumulator.
// Used by swa_mac, swa_ctrl and skinning_weight_accumulator; depends on nothing.
package swa_pkg;

  localparam int Q_W    = 16;
  localparam int POS_W  = 24;
  localparam int WT_W   = 16;
  localparam int OUT_W  = 24;

  localparam int PROD_W = 32;
  localparam int MC_W   = 34;
  localparam int ML_W   = 24;
  localparam int ACC_W  = 60;
  localparam int SUM_W  = 48;
  localparam int T_W    = 28;

  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = ML_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(MUL_DIGITS);

  localparam int NUM_PROD = 9;
  localparam int NUM_OPS  = NUM_PROD + 3 * 4;
  localparam int OP_W     = $clog2(NUM_OPS);

  localparam int DOT_SHIFT = 30;
  localparam int OUT_SHIFT = 16;

  localparam int IN_POS_LSB = 4 * Q_W;
  localparam int IN_OFF_LSB = IN_POS_LSB + 3 * POS_W;
  localparam int IN_WT_LSB  = IN_OFF_LSB + 3 * POS_W;
  localparam int IN_DATA_W  = IN_WT_LSB + WT_W;
  localparam int OUT_DATA_W = 3 * OUT_W;

  localparam logic signed [MC_W-1:0] ONE_Q30 = MC_W'(64'd1 << DOT_SHIFT);

  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;

  typedef enum logic [1:0] {
    OP_PROD,
    OP_DOT,
    OP_WGT
  } op_kind_t;

  typedef enum logic [1:0] {
    INIT_ZERO,
    INIT_KEEP,
    INIT_SUM
  } acc_init_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] pidx;
    logic [1:0] row;
    logic [1:0] col;
  } op_info_t;

  typedef struct packed {
    logic      take;
    logic      start;
    acc_init_t init;
    op_info_t  op;
    logic      post;
    logic      emit;
  } swa_ctl_t;

  // Nine quaternion products come first, then for each axis three dot terms and one weighting.
  function automatic op_info_t decode_op(input logic [OP_W-1:0] op);
    op_info_t        info;
    logic [OP_W-1:0] rel;
    rel       = op - OP_W'(NUM_PROD);
    info.pidx = op[3:0];
    info.row  = rel[3:2];
    info.col  = rel[1:0];
    if (op < OP_W'(NUM_PROD)) begin
      info.kind = OP_PROD;
    end else if (rel[1:0] == 2'd3) begin
      info.kind = OP_WGT;
    end else begin
      info.kind = OP_DOT;
    end
    return info;
  endfunction

endpackage

// ----- design/swa_mac.sv -----
`timescale 1ns / 1ps
// Digit-serial signed multiply-accumulate unit, four multiplier bits per cycle.
// Depends on swa_pkg for widths and the accumulator start modes.
module swa_mac import swa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  acc_init_t               init,
  input  logic signed [MC_W-1:0]  mcand,
  input  logic signed [ML_W-1:0]  mult,
  input  logic signed [SUM_W-1:0] sum_in,
  output logic signed [ACC_W-1:0] acc,
  output logic                    busy
);

  logic signed [ACC_W-1:0]       mc_sh;
  logic signed [ML_W-1:0]        ml_sh;
  logic [DCNT_W-1:0]             cnt;
  logic                          last_digit;
  logic signed [DIGIT_W:0]       digit;
  logic signed [ACC_W+DIGIT_W:0] pp_full;
  logic signed [ACC_W-1:0]       pp;

  // The top digit carries the sign of the multiplier.
  assign last_digit = (cnt == DCNT_W'(MUL_DIGITS - 1));
  assign digit = last_digit ? {ml_sh[DIGIT_W-1], ml_sh[DIGIT_W-1:0]}
                            : {1'b0, ml_sh[DIGIT_W-1:0]};
  assign pp_full = mc_sh * digit;
  assign pp = pp_full[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DCNT_W'(1);
      if (last_digit) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_sh <= {{(ACC_W-MC_W){mcand[MC_W-1]}}, mcand};
      ml_sh <= mult;
      case (init)
        INIT_ZERO: begin
          acc <= '0;
        end
        INIT_SUM: begin
          acc <= {{(ACC_W-SUM_W){sum_in[SUM_W-1]}}, sum_in};
        end
        INIT_KEEP: begin
          acc <= acc;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end else if (busy) begin
      acc   <= acc + pp;
      mc_sh <= mc_sh <<< DIGIT_W;
      ml_sh <= ml_sh >>> DIGIT_W;
    end
  end

endmodule

// ----- design/swa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer that walks one weight through its 21 multiply-accumulate operations.
// Depends on swa_pkg for the state type, the operation schedule and the control struct.
module swa_ctrl import swa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     mac_busy,
  input  logic     last_flag,
  input  logic     out_free,
  output logic     in_ready,
  output swa_ctl_t ctl
);

  state_t          state;
  state_t          state_next;
  logic [OP_W-1:0] op;
  logic [OP_W-1:0] op_next;
  op_info_t        info;

  assign info = decode_op(op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.op     = info;
    case (info.kind)
      OP_PROD: begin
        ctl.init = INIT_ZERO;
      end
      OP_DOT: begin
        ctl.init = (info.col == 2'd0) ? INIT_ZERO : INIT_KEEP;
      end
      OP_WGT: begin
        ctl.init = INIT_SUM;
      end
      default: begin
        ctl.init = INIT_ZERO;
      end
    endcase
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctl.take   = 1'b1;
          op_next    = '0;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctl.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!mac_busy) begin
          ctl.post = 1'b1;
          if (op == OP_W'(NUM_OPS - 1)) begin
            state_next = last_flag ? S_EMIT : S_IDLE;
          end else begin
            op_next    = op + OP_W'(1);
            state_next = S_ISSUE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/skinning_weight_accumulator.sv -----
`timescale 1ns / 1ps
// Top level of the skinning weight accumulator: input capture, matrix forming, sums and output.
// Depends on swa_pkg, swa_mac and swa_ctrl.
//
// Each transaction on the s_axis channel is one weight of a vertex; s_axis_tlast marks the
// last weight. The block builds the rotation matrix from the joint quaternion, rotates the
// bind offset, adds the joint position, scales by the weight and adds the result to three
// 48-bit saturating sums. After the last weight of a vertex one transaction leaves on
// m_axis with the rounded, saturated position, and the sums are cleared.
// All arithmetic runs on one digit-serial multiply-accumulate unit that takes 4 multiplier
// bits per cycle. Each product is issued, accumulated over its 6 digits and stored, and a
// weight needs 21 products. After the last weight of a vertex an emit step loads the output
// register and raises m_axis_tvalid. One weight is processed at a time; s_axis_tready is
// high only between weights. The result sits in an output register, so the next weight is
// accepted while it waits. If a new result is ready while the previous one is still held by
// a stalled receiver, the block waits until that result is taken. Reset clears the sums,
// drops m_axis_tvalid and holds s_axis_tready low.
module skinning_weight_accumulator import swa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // joint_rot_w, joint_rot_x, joint_rot_y, joint_rot_z, joint_pos_x, joint_pos_y,
  // joint_pos_z, offset_x, offset_y, offset_z, weight_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x, out_y, out_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  swa_ctl_t                ctl;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] acc;

  logic signed [Q_W-1:0]    q_w;
  logic signed [Q_W-1:0]    q_x;
  logic signed [Q_W-1:0]    q_y;
  logic signed [Q_W-1:0]    q_z;
  logic signed [POS_W-1:0]  jp [3];
  logic signed [POS_W-1:0]  off [3];
  logic [WT_W-1:0]          weight;
  logic                     last_flag;
  logic signed [PROD_W-1:0] prod [NUM_PROD];
  logic signed [MC_W-1:0]   pe [NUM_PROD];
  logic signed [T_W-1:0]    t_val;
  logic signed [SUM_W-1:0]  sums [3];
  logic [OUT_W-1:0]         out_val [3];

  logic signed [Q_W-1:0]   pa;
  logic signed [Q_W-1:0]   pb;
  logic signed [MC_W-1:0]  mat_sel;
  logic signed [POS_W-1:0] jp_sel;
  logic signed [POS_W-1:0] off_sel;
  logic signed [SUM_W-1:0] sum_sel;
  logic signed [MC_W-1:0]  mcand;
  logic signed [ML_W-1:0]  mult;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [T_W-1:0]   t_next;
  logic signed [SUM_W-1:0] acc_sat;
  logic                    out_free;

  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .mac_busy  (mac_busy),
    .last_flag (last_flag),
    .out_free  (out_free),
    .in_ready  (s_axis_tready),
    .ctl       (ctl)
  );

  swa_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.start),
    .init   (ctl.init),
    .mcand  (mcand),
    .mult   (mult),
    .sum_in (sum_sel),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      q_w       <= s_axis_tdata[0 +: Q_W];
      q_x       <= s_axis_tdata[Q_W +: Q_W];
      q_y       <= s_axis_tdata[2*Q_W +: Q_W];
      q_z       <= s_axis_tdata[3*Q_W +: Q_W];
      for (int i = 0; i < 3; i++) begin
        jp[i]  <= s_axis_tdata[IN_POS_LSB + i*POS_W +: POS_W];
        off[i] <= s_axis_tdata[IN_OFF_LSB + i*POS_W +: POS_W];
      end
      weight    <= s_axis_tdata[IN_WT_LSB +: WT_W];
      last_flag <= s_axis_tlast;
    end
  end

  always_comb begin
    case (ctl.op.pidx)
      4'(P_XX): begin pa = q_x; pb = q_x; end
      4'(P_YY): begin pa = q_y; pb = q_y; end
      4'(P_ZZ): begin pa = q_z; pb = q_z; end
      4'(P_XY): begin pa = q_x; pb = q_y; end
      4'(P_XZ): begin pa = q_x; pb = q_z; end
      4'(P_YZ): begin pa = q_y; pb = q_z; end
      4'(P_WX): begin pa = q_w; pb = q_x; end
      4'(P_WY): begin pa = q_w; pb = q_y; end
      4'(P_WZ): begin pa = q_w; pb = q_z; end
      default: begin pa = q_w; pb = q_w; end
    endcase
  end

  for (genvar i = 0; i < NUM_PROD; i++) begin : g_pe
    assign pe[i] = {{(MC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
  end

  always_comb begin
    case ({ctl.op.row, ctl.op.col})
      4'b00_00: mat_sel = ONE_Q30 - ((pe[P_YY] + pe[P_ZZ]) <<< 1);
      4'b00_01: mat_sel = (pe[P_XY] - pe[P_WZ]) <<< 1;
      4'b00_10: mat_sel = (pe[P_XZ] + pe[P_WY]) <<< 1;
      4'b01_00: mat_sel = (pe[P_XY] + pe[P_WZ]) <<< 1;
      4'b01_01: mat_sel = ONE_Q30 - ((pe[P_XX] + pe[P_ZZ]) <<< 1);
      4'b01_10: mat_sel = (pe[P_YZ] - pe[P_WX]) <<< 1;
      4'b10_00: mat_sel = (pe[P_XZ] - pe[P_WY]) <<< 1;
      4'b10_01: mat_sel = (pe[P_YZ] + pe[P_WX]) <<< 1;
      4'b10_10: mat_sel = ONE_Q30 - ((pe[P_XX] + pe[P_YY]) <<< 1);
      default:  mat_sel = '0;
    endcase
  end

  always_comb begin
    case (ctl.op.row)
      2'd0: begin jp_sel = jp[0]; sum_sel = sums[0]; end
      2'd1: begin jp_sel = jp[1]; sum_sel = sums[1]; end
      default: begin jp_sel = jp[2]; sum_sel = sums[2]; end
    endcase
    case (ctl.op.col)
      2'd0: off_sel = off[0];
      2'd1: off_sel = off[1];
      default: off_sel = off[2];
    endcase
  end

  always_comb begin
    case (ctl.op.kind)
      OP_PROD: begin
        mcand = {{(MC_W-Q_W){pa[Q_W-1]}}, pa};
        mult  = {{(ML_W-Q_W){pb[Q_W-1]}}, pb};
      end
      OP_DOT: begin
        mcand = mat_sel;
        mult  = off_sel;
      end
      OP_WGT: begin
        mcand = {{(MC_W-T_W){t_val[T_W-1]}}, t_val};
        mult  = {{(ML_W-WT_W){1'b0}}, weight};
      end
      default: begin
        mcand = '0;
        mult  = '0;
      end
    endcase
  end

  // Round the dot product half up to Q16.8, then add the joint position.
  assign acc_rnd = acc + (ACC_W'(1) <<< (DOT_SHIFT - 1));
  assign t_next  = acc_rnd[DOT_SHIFT +: T_W] + {{(T_W-POS_W){jp_sel[POS_W-1]}}, jp_sel};

  always_comb begin
    if ((&acc[ACC_W-1:SUM_W-1]) || !(|acc[ACC_W-1:SUM_W-1])) begin
      acc_sat = acc[SUM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.post) begin
      if (ctl.op.kind == OP_PROD) begin
        prod[ctl.op.pidx] <= acc[PROD_W-1:0];
      end
      if ((ctl.op.kind == OP_DOT) && (ctl.op.col == 2'd2)) begin
        t_val <= t_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else if (ctl.emit) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else if (ctl.post && (ctl.op.kind == OP_WGT)) begin
      case (ctl.op.row)
        2'd0: sums[0] <= acc_sat;
        2'd1: sums[1] <= acc_sat;
        default: sums[2] <= acc_sat;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic signed [SUM_W:0]           o_rnd;
    logic signed [SUM_W-OUT_SHIFT:0] o_sh;
    assign o_rnd = {sums[i][SUM_W-1], sums[i]} + ((SUM_W+1)'(1) <<< (OUT_SHIFT - 1));
    assign o_sh  = o_rnd[SUM_W:OUT_SHIFT];
    always_comb begin
      if ((&o_sh[SUM_W-OUT_SHIFT:OUT_W-1]) || !(|o_sh[SUM_W-OUT_SHIFT:OUT_W-1])) begin
        out_val[i] = o_sh[OUT_W-1:0];
      end else if (o_sh[SUM_W-OUT_SHIFT]) begin
        out_val[i] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        out_val[i] = {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_axis_tdata <= {out_val[2], out_val[1], out_val[0]};
    end
  end

endmodule
